FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that is checked on every rising edge outside reset.
`define OCC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define OCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/occ_pkg.sv
`default_nettype none
package occ_pkg;
    localparam int COORD_WIDTH_DEF   = 24;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_COUNT        = 24;
    localparam int ANG_W             = 34;
    localparam int CS_W              = 34;
    localparam int ROT_W             = 16;
    localparam logic signed [CS_W-1:0] GAIN_Q30 = 34'sd652032874;

    function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
        logic signed [ANG_W-1:0] r;
        r = '0;
        case (i)
            0:  r = 34'sd536870912;
            1:  r = 34'sd316933406;
            2:  r = 34'sd167458907;
            3:  r = 34'sd85004756;
            4:  r = 34'sd42667331;
            5:  r = 34'sd21354465;
            6:  r = 34'sd10679838;
            7:  r = 34'sd5340245;
            8:  r = 34'sd2670163;
            9:  r = 34'sd1335087;
            10: r = 34'sd667544;
            11: r = 34'sd333772;
            12: r = 34'sd166886;
            13: r = 34'sd83443;
            14: r = 34'sd41722;
            15: r = 34'sd20861;
            16: r = 34'sd10430;
            17: r = 34'sd5215;
            18: r = 34'sd2608;
            19: r = 34'sd1304;
            20: r = 34'sd652;
            21: r = 34'sd326;
            22: r = 34'sd163;
            23: r = 34'sd81;
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

FILE: rtl/occ_cordic_cell.sv
`default_nettype none
module occ_cordic_cell
    import occ_pkg::*;
#(
    parameter int STAGE = 0,
    parameter int PW    = 8
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    vin,
    input  wire logic signed [CS_W-1:0]  xin,
    input  wire logic signed [CS_W-1:0]  yin,
    input  wire logic signed [ANG_W-1:0] zin,
    input  wire logic [PW-1:0]           pin,
    output logic                         vout,
    output logic signed [CS_W-1:0]       xout,
    output logic signed [CS_W-1:0]       yout,
    output logic signed [ANG_W-1:0]      zout,
    output logic [PW-1:0]                pout
);
    logic signed [CS_W-1:0]  x_next, y_next;
    logic signed [ANG_W-1:0] z_next;

    always_comb
    begin
        if (!zin[ANG_W-1])
        begin
            x_next = xin - (yin >>> STAGE);
            y_next = yin + (xin >>> STAGE);
            z_next = zin - atan_entry(STAGE);
        end
        else
        begin
            x_next = xin + (yin >>> STAGE);
            y_next = yin - (xin >>> STAGE);
            z_next = zin + atan_entry(STAGE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vout <= 1'b0;
        else
            vout <= vin;
    end

    always_ff @(posedge clk)
    begin
        xout <= x_next;
        yout <= y_next;
        zout <= z_next;
        pout <= pin;
    end
endmodule
`default_nettype wire

FILE: rtl/occ_order.sv
`default_nettype none
module occ_order
    import occ_pkg::*;
#(
    parameter int DW = 30
)
(
    input  wire logic signed [DW-1:0] ax,
    input  wire logic signed [DW-1:0] ay,
    input  wire logic signed [DW-1:0] bx,
    input  wire logic signed [DW-1:0] by,
    output logic                      less
);
    logic [1:0] ca, cb;
    logic signed [2*DW:0] p1, p2;

    function automatic logic [1:0] cls(input logic signed [DW-1:0] x,
                                       input logic signed [DW-1:0] y);
        logic [1:0] c;
        if (y < 0)                c = 2'd0;
        else if (y == 0 && x >= 0) c = 2'd1;
        else if (y > 0)           c = 2'd2;
        else                      c = 2'd3;
        return c;
    endfunction

    always_comb
    begin
        ca = cls(ax, ay);
        cb = cls(bx, by);
        p1 = (2*DW+1)'(ax) * (2*DW+1)'(by);
        p2 = (2*DW+1)'(ay) * (2*DW+1)'(bx);
        if (ca != cb)
            less = ca < cb;
        else if (ca == 2'd1 || ca == 2'd3)
            less = 1'b0;
        else
            less = p1 > p2;
    end
endmodule
`default_nettype wire

FILE: rtl/obb_canonical_corners_core.sv
// Oriented box to four ordered corners. One request per cycle, never stalls:
// busy is held low. A request's corners appear on the corner ports with done
// high once it has passed the rotator cells (one per CORDIC stage, at most
// ATAN_COUNT), then the fold/round, scale, offset, sum, order and start-select/
// output stages. The receiver cannot stall; done lasts one cycle per request.
`default_nettype none
module obb_canonical_corners_core
    import occ_pkg::*;
#(
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [COORD_WIDTH-1:0] center_x,
    input  wire logic signed [COORD_WIDTH-1:0] center_y,
    input  wire logic [COORD_WIDTH-1:0]        box_width,
    input  wire logic [COORD_WIDTH-1:0]        box_height,
    input  wire logic [ROT_W-1:0]              rotation,
    output logic                               done,
    output logic signed [COORD_WIDTH+1:0]      corner0_x,
    output logic signed [COORD_WIDTH+1:0]      corner0_y,
    output logic signed [COORD_WIDTH+1:0]      corner1_x,
    output logic signed [COORD_WIDTH+1:0]      corner1_y,
    output logic signed [COORD_WIDTH+1:0]      corner2_x,
    output logic signed [COORD_WIDTH+1:0]      corner2_y,
    output logic signed [COORD_WIDTH+1:0]      corner3_x,
    output logic signed [COORD_WIDTH+1:0]      corner3_y
);
    localparam int CW = COORD_WIDTH;
    localparam int OW = CW + 2;
    localparam int PW = 4 * CW + 2;
    localparam int PRW = CW + 1 + 29;
    localparam int OFW = CW + 2;
    localparam int DW  = CW + 6;
    localparam int PXW = CW + 3;
    localparam int NS = (CORDIC_STAGES < ATAN_COUNT) ? CORDIC_STAGES : ATAN_COUNT;

    assign busy = 1'b0;

    logic                    cv [0:NS];
    logic signed [CS_W-1:0]  cx_c [0:NS];
    logic signed [CS_W-1:0]  cy_c [0:NS];
    logic signed [ANG_W-1:0] cz_c [0:NS];
    logic [PW-1:0]           cp [0:NS];

    logic [CW-1:0] w_in, h_in;
    assign w_in = (box_width == '0) ? CW'(1) : box_width;
    assign h_in = (box_height == '0) ? CW'(1) : box_height;

    assign cv[0]   = start;
    assign cx_c[0] = GAIN_Q30;
    assign cy_c[0] = '0;
    assign cz_c[0] = {4'b0, rotation[13:0], 16'b0};
    assign cp[0]   = {rotation[15:14], center_x, center_y, w_in, h_in};

    for (genvar g = 0; g < NS; g++)
    begin : g_cell
        occ_cordic_cell #(.STAGE(g), .PW(PW)) u_cell (
            .clk(clk), .rst_n(rst_n),
            .vin(cv[g]), .xin(cx_c[g]), .yin(cy_c[g]), .zin(cz_c[g]), .pin(cp[g]),
            .vout(cv[g+1]), .xout(cx_c[g+1]), .yout(cy_c[g+1]), .zout(cz_c[g+1]),
            .pout(cp[g+1])
        );
    end

    // stage A: quadrant fold and round to Q28
    logic [1:0] q;
    logic signed [CS_W-1:0] c30, s30;
    logic signed [CW-1:0] pcx, pcy;
    logic [CW-1:0] pw, ph;
    assign {q, pcx, pcy, pw, ph} = cp[NS];
    always_comb
    begin
        case (q)
            2'd0:    begin c30 = cx_c[NS];  s30 = cy_c[NS];  end
            2'd1:    begin c30 = -cy_c[NS]; s30 = cx_c[NS];  end
            2'd2:    begin c30 = -cx_c[NS]; s30 = -cy_c[NS]; end
            default: begin c30 = cy_c[NS];  s30 = -cx_c[NS]; end
        endcase
    end

    logic a_v_reg;
    logic signed [31:0] a_c_reg, a_s_reg;
    logic signed [CW-1:0] a_cx_reg, a_cy_reg;
    logic [CW-1:0] a_w_reg, a_h_reg;
    logic signed [CS_W-1:0] c_rnd, s_rnd;
    assign c_rnd = (c30 + CS_W'(2)) >>> 2;
    assign s_rnd = (s30 + CS_W'(2)) >>> 2;

    // stage B: products
    logic b_v_reg;
    logic signed [PRW-1:0] b_wc_reg, b_ws_reg, b_hc_reg, b_hs_reg;
    logic signed [CW-1:0] b_cx_reg, b_cy_reg;

    // stage C: offsets
    logic c_v_reg;
    logic signed [OFW-1:0] c_ox_reg [4];
    logic signed [OFW-1:0] c_oy_reg [4];
    logic signed [CW-1:0] c_cx_reg, c_cy_reg;
    logic signed [PRW+1:0] nx [4], ny [4];
    always_comb
    begin
        nx[0] = -PRW'(0) - b_wc_reg + b_hs_reg;
        ny[0] = -b_ws_reg - b_hc_reg;
        nx[1] = b_wc_reg + b_hs_reg;
        ny[1] = b_ws_reg - b_hc_reg;
        nx[2] = b_wc_reg - b_hs_reg;
        ny[2] = b_ws_reg + b_hc_reg;
        nx[3] = -b_wc_reg - b_hs_reg;
        ny[3] = -b_ws_reg + b_hc_reg;
    end

    // stage D: deltas and positions
    logic d_v_reg;
    logic signed [DW-1:0] d_dx_reg [4], d_dy_reg [4];
    logic signed [PXW-1:0] d_px_reg [4], d_py_reg [4];
    logic signed [OFW+1:0] sx, sy;
    assign sx = (OFW+2)'(c_ox_reg[0]) + c_ox_reg[1] + c_ox_reg[2] + c_ox_reg[3];
    assign sy = (OFW+2)'(c_oy_reg[0]) + c_oy_reg[1] + c_oy_reg[2] + c_oy_reg[3];

    // stage E: pairwise order compares
    logic [3:0][3:0] lt;
    for (genvar i = 0; i < 4; i++)
    begin : g_ci
        for (genvar j = 0; j < 4; j++)
        begin : g_cj
            occ_order #(.DW(DW)) u_ord (
                .ax(d_dx_reg[i]), .ay(d_dy_reg[i]),
                .bx(d_dx_reg[j]), .by(d_dy_reg[j]), .less(lt[i][j])
            );
        end
    end
    // stable rank: count j strictly less, or equal and earlier
    logic [1:0] rank [4];
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < 4; j++)
                if (j != i && (lt[j][i] || (j < i && !lt[i][j])))
                    rank[i] = rank[i] + 2'd1;
        end
    end

    logic e_v_reg;
    logic signed [PXW-1:0] e_x_reg [4], e_y_reg [4];
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            e_x_reg[rank[i]] <= d_px_reg[i];
            e_y_reg[rank[i]] <= d_py_reg[i];
        end
    end

    // stage F: start corner and saturation
    logic [1:0] st;
    always_comb
    begin
        st = 2'd0;
        for (int k = 1; k < 4; k++)
            if (e_y_reg[k] < e_y_reg[st] ||
                (e_y_reg[k] == e_y_reg[st] && e_x_reg[k] < e_x_reg[st]))
                st = 2'(k);
    end

    function automatic logic signed [OW-1:0] sat(input logic signed [PXW-1:0] v);
        logic signed [PXW-1:0] hi, lo;
        hi = PXW'({1'b0, {(OW-1){1'b1}}});
        lo = ~hi;
        if (v > hi)      return hi[OW-1:0];
        else if (v < lo) return lo[OW-1:0];
        else             return v[OW-1:0];
    endfunction

    logic f_v_reg;
    logic signed [OW-1:0] f_x_reg [4], f_y_reg [4];
    logic [1:0] sel [4];
    always_comb
        for (int k = 0; k < 4; k++)
            sel[k] = st + 2'(k);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= cv[NS];
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
            e_v_reg <= d_v_reg;
            f_v_reg <= e_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_c_reg  <= c_rnd[31:0];
        a_s_reg  <= s_rnd[31:0];
        a_cx_reg <= pcx;
        a_cy_reg <= pcy;
        a_w_reg  <= pw;
        a_h_reg  <= ph;

        b_wc_reg <= PRW'($signed({1'b0, a_w_reg}) * a_c_reg);
        b_ws_reg <= PRW'($signed({1'b0, a_w_reg}) * a_s_reg);
        b_hc_reg <= PRW'($signed({1'b0, a_h_reg}) * a_c_reg);
        b_hs_reg <= PRW'($signed({1'b0, a_h_reg}) * a_s_reg);
        b_cx_reg <= a_cx_reg;
        b_cy_reg <= a_cy_reg;

        for (int k = 0; k < 4; k++)
        begin
            c_ox_reg[k] <= OFW'((nx[k] + (PRW+2)'(1 << 28)) >>> 29);
            c_oy_reg[k] <= OFW'((ny[k] + (PRW+2)'(1 << 28)) >>> 29);
        end
        c_cx_reg <= b_cx_reg;
        c_cy_reg <= b_cy_reg;

        for (int k = 0; k < 4; k++)
        begin
            d_dx_reg[k] <= DW'(((OFW+2)'(c_ox_reg[k]) <<< 2) - sx);
            d_dy_reg[k] <= DW'(((OFW+2)'(c_oy_reg[k]) <<< 2) - sy);
            d_px_reg[k] <= PXW'(c_cx_reg) + PXW'(c_ox_reg[k]);
            d_py_reg[k] <= PXW'(c_cy_reg) + PXW'(c_oy_reg[k]);
        end

        for (int k = 0; k < 4; k++)
        begin
            f_x_reg[k] <= sat(e_x_reg[sel[k]]);
            f_y_reg[k] <= sat(e_y_reg[sel[k]]);
        end
    end

    assign done      = f_v_reg;
    assign corner0_x = f_x_reg[0];
    assign corner0_y = f_y_reg[0];
    assign corner1_x = f_x_reg[1];
    assign corner1_y = f_y_reg[1];
    assign corner2_x = f_x_reg[2];
    assign corner2_y = f_y_reg[2];
    assign corner3_x = f_x_reg[3];
    assign corner3_y = f_y_reg[3];
endmodule
`default_nettype wire

FILE: rtl/occ_checker.sv
`default_nettype none
`include "assert_macros.svh"
module occ_checker
    import occ_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          done,
    input wire logic signed [COORD_WIDTH+1:0] corner0_y,
    input wire logic signed [COORD_WIDTH+1:0] corner1_y,
    input wire logic signed [COORD_WIDTH+1:0] corner2_y,
    input wire logic signed [COORD_WIDTH+1:0] corner3_y
);
    `OCC_ASSERT(a_never_busy, !busy, "busy raised")
    `OCC_ASSERT(a_start_min_y, !done || (corner0_y <= corner1_y && corner0_y <= corner2_y
        && corner0_y <= corner3_y), "first corner not lowest y")
    `OCC_ASSERT_NEXT(a_done_known, 1'b1, !$isunknown(done), "done unknown")
    `OCC_ASSERT(a_start_known, !$isunknown(start), "start unknown")
endmodule

bind obb_canonical_corners_core occ_checker #(.COORD_WIDTH(COORD_WIDTH)) u_occ_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .corner0_y(corner0_y), .corner1_y(corner1_y),
    .corner2_y(corner2_y), .corner3_y(corner3_y)
);
`default_nettype wire

FILE: tb/obb_canonical_corners_core_tb.sv
`default_nettype none
module obb_canonical_corners_core_tb
    import occ_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = COORD_WIDTH_DEF;
    localparam int OW = CW + 2;
    localparam int STAGES = CORDIC_STAGES_DEF;
    localparam int LATENCY = STAGES + 7;

    typedef struct packed {
        logic signed [OW-1:0] x0, y0, x1, y1, x2, y2, x3, y3;
    } corners_t;

    logic clk, rst_n, start;
    logic busy, done;
    logic signed [CW-1:0] center_x, center_y;
    logic [CW-1:0] box_width, box_height;
    logic [ROT_W-1:0] rotation;
    logic signed [OW-1:0] corner0_x, corner0_y, corner1_x, corner1_y;
    logic signed [OW-1:0] corner2_x, corner2_y, corner3_x, corner3_y;

    corners_t corners_due[$];
    int mismatches;
    bit idle_ok;

    obb_canonical_corners_core uut (.*);

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("obb_canonical_corners_core_tb: FAIL");
        $finish;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic int angle_class(longint x, longint y);
        if (y < 0) return 0;
        if (y == 0 && x >= 0) return 1;
        if (y > 0) return 2;
        return 3;
    endfunction

    // a ahead of b in angle; products fit in 128 bits exactly
    function automatic bit angle_ahead(longint ax, longint ay, longint bx, longint by);
        int ca, cb;
        logic signed [127:0] p1, p2;
        ca = angle_class(ax, ay);
        cb = angle_class(bx, by);
        if (ca != cb) return ca < cb;
        if (ca == 1 || ca == 3) return 0;
        p1 = 128'(ax) * 128'(by);
        p2 = 128'(ay) * 128'(bx);
        return p1 > p2;
    endfunction

    function automatic logic signed [OW-1:0] clamp_out(longint v);
        longint hi, lo;
        hi = (longint'(1) <<< (OW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[OW-1:0];
    endfunction

    function automatic corners_t box_corners(logic signed [CW-1:0] cx, logic signed [CW-1:0] cy,
                                             logic [CW-1:0] bw, logic [CW-1:0] bh,
                                             logic [ROT_W-1:0] rot);
        longint x, y, z, tx, c30, s30, c28, s28, w, h, nx, ny, sx, sy, sumx, sumy;
        longint ox[4], oy[4], dx[4], dy[4], px[4], py[4];
        int ord[4];
        int cur, j, first, a, b, p;
        corners_t r;
        x = GAIN_Q30;
        y = 0;
        z = longint'(rot[13:0]) <<< 16;
        for (int i = 0; i < STAGES && i < ATAN_COUNT; i++)
        begin
            tx = x;
            if (z >= 0)
            begin
                x = x - (y >>> i); y = y + (tx >>> i); z = z - atan_entry(i);
            end
            else
            begin
                x = x + (y >>> i); y = y - (tx >>> i); z = z + atan_entry(i);
            end
        end
        case (rot[15:14])
            2'd0: begin c30 = x;  s30 = y;  end
            2'd1: begin c30 = -y; s30 = x;  end
            2'd2: begin c30 = -x; s30 = -y; end
            default: begin c30 = y; s30 = -x; end
        endcase
        c28 = floor_shift(c30 + 2, 2);
        s28 = floor_shift(s30 + 2, 2);
        w = (bw == 0) ? 1 : longint'(bw);
        h = (bh == 0) ? 1 : longint'(bh);
        sumx = 0;
        sumy = 0;
        for (int k = 0; k < 4; k++)
        begin
            sx = (k == 0 || k == 3) ? -1 : 1;
            sy = (k < 2) ? -1 : 1;
            nx = sx * w * c28 - sy * h * s28;
            ny = sx * w * s28 + sy * h * c28;
            ox[k] = floor_shift(nx + (longint'(1) <<< 28), 29);
            oy[k] = floor_shift(ny + (longint'(1) <<< 28), 29);
            sumx += ox[k];
            sumy += oy[k];
            ord[k] = k;
        end
        for (int k = 0; k < 4; k++)
        begin
            dx[k] = 4 * ox[k] - sumx;
            dy[k] = 4 * oy[k] - sumy;
            px[k] = longint'(cx) + ox[k];
            py[k] = longint'(cy) + oy[k];
        end
        for (int k = 1; k < 4; k++)
        begin
            cur = ord[k];
            j = k;
            while (j > 0 && angle_ahead(dx[cur], dy[cur], dx[ord[j-1]], dy[ord[j-1]]))
            begin
                ord[j] = ord[j-1];
                j--;
            end
            ord[j] = cur;
        end
        first = 0;
        for (int k = 1; k < 4; k++)
        begin
            a = ord[k];
            b = ord[first];
            if (py[a] < py[b] || (py[a] == py[b] && px[a] < px[b])) first = k;
        end
        p = ord[first];           r.x0 = clamp_out(px[p]); r.y0 = clamp_out(py[p]);
        p = ord[(first + 1) & 3]; r.x1 = clamp_out(px[p]); r.y1 = clamp_out(py[p]);
        p = ord[(first + 2) & 3]; r.x2 = clamp_out(px[p]); r.y2 = clamp_out(py[p]);
        p = ord[(first + 3) & 3]; r.x3 = clamp_out(px[p]); r.y3 = clamp_out(py[p]);
        return r;
    endfunction

    task automatic send_box(logic signed [CW-1:0] cx, logic signed [CW-1:0] cy,
                            logic [CW-1:0] bw, logic [CW-1:0] bh, logic [ROT_W-1:0] rot);
        int gap;
        if (idle_ok && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            start <= 0;
            repeat (gap) @(negedge clk);
        end
        start <= 1;
        center_x <= cx;
        center_y <= cy;
        box_width <= bw;
        box_height <= bh;
        rotation <= rot;
        @(posedge clk);
        while (busy) @(posedge clk);
        corners_due.insert(corners_due.size(), box_corners(cx, cy, bw, bh, rot));
        @(negedge clk);
    endtask

    task automatic stop_sending();
        start <= 0;
        @(negedge clk);
    endtask

    task automatic drain();
        stop_sending();
        while (corners_due.size() != 0) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        corners_t got, want;
        if (rst_n && done)
        begin
            got = '{corner0_x, corner0_y, corner1_x, corner1_y,
                    corner2_x, corner2_y, corner3_x, corner3_y};
            if (corners_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end
            else
            begin
                want = corners_due.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", want, got);
                end
            end
        end
    end

    task automatic test_extremes();
        logic [CW-1:0] sizes[4] = '{0, 1, 24'h000100, 24'hFFFFFF};
        logic signed [CW-1:0] ctr[3] = '{24'sh800000, 0, 24'sh7FFFFF};
        foreach (ctr[i])
            foreach (sizes[j])
                send_box(ctr[i], ctr[2 - i], sizes[j], sizes[3 - j],
                         16'(j * 16384));
        send_box(0, 0, 0, 0, 16'hFFFF);
        send_box(24'sh7FFFFF, 24'sh800000, 24'hFFFFFF, 24'hFFFFFF, 16'h2000);
        drain();
    endtask

    task automatic test_quadrant_edges();
        logic [ROT_W-1:0] angs[8] = '{16'h0000, 16'h3FFF, 16'h4000, 16'h7FFF,
                                      16'h8000, 16'hBFFF, 16'hC000, 16'h1000};
        foreach (angs[i])
            send_box(24'sh001000, -24'sh002000, 24'h003000, 24'h001800, angs[i]);
        drain();
    endtask

    task automatic test_random(int n);
        logic [CW-1:0] bw, bh;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 3))
                0: begin bw = CW'($urandom); bh = CW'($urandom); end
                1: begin bw = CW'($urandom_range(0, 4)); bh = CW'($urandom_range(0, 4)); end
                2: begin bw = CW'($urandom_range(0, 24'h00FFFF)); bh = bw; end
                default: begin bw = CW'($urandom_range(0, 24'h00FFFF));
                               bh = CW'($urandom_range(0, 24'h00FFFF)); end
            endcase
            send_box(CW'($urandom), CW'($urandom), bw, bh,
                     ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 7) * 8192)
                                                 : 16'($urandom));
        end
    endtask

    initial
    begin
        mismatches = 0;
        idle_ok = 0;
        rst_n = 0;
        start = 0;
        center_x = 0;
        center_y = 0;
        box_width = 0;
        box_height = 0;
        rotation = 0;
        repeat (9) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        test_extremes();
        test_quadrant_edges();
        idle_ok = 1;
        test_random(1500);
        drain();
        idle_ok = 0;
        test_random(400);
        drain();
        repeat (LATENCY + 5) @(negedge clk);
        if (mismatches == 0 && corners_due.size() == 0)
            $display("obb_canonical_corners_core_tb: PASS");
        else
            $display("obb_canonical_corners_core_tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

FILE: obb_canonical_corners_core.f
+incdir+rtl
rtl/occ_pkg.sv
rtl/occ_cordic_cell.sv
rtl/occ_order.sv
rtl/obb_canonical_corners_core.sv
rtl/occ_checker.sv
tb/obb_canonical_corners_core_tb.sv
